FILE: rtl/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg
// Shared operation codes and fixed-point constants of the bilinear sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_WRITE  = 2'd0;
  localparam op_t OP_SAMPLE = 2'd1;
  localparam op_t OP_ZERO   = 2'd2;

  localparam int PIX_W  = 8;
  localparam int FRAC_W = 16;
  localparam int OUT_W  = 16;
  localparam int CFG_W  = 9;

  localparam logic [FRAC_W:0] FIX_ONE = 17'h10000;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/bms_queue.sv
// ----------------------------------------------------------------------------
// bms_queue
// Two-entry request queue between the classifying front and the sampling back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bms_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic [1:0]   count_nxt;
  logic         do_pop;

  assign valid_o = (count_r != 2'd0);
  assign full_o  = (count_r == 2'd2);
  assign data_o  = mem_r[rd_ptr_r];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_nxt = count_r;
    if (push_i && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push_i && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (!full_o || do_pop))
    else $error("request pushed into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !push_i && count_r == 2'd1) |=> !valid_o)
    else $error("queue not empty after last pop");

endmodule

`default_nettype wire

FILE: rtl/bms_front.sv
// ----------------------------------------------------------------------------
// bms_front
// Holds the image size, takes requests, classifies them and scales the
// coordinates into pixel space before queueing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bms_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int EW         = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_action,
  input  wire logic [7:0]                  in_pixel_column,
  input  wire logic [7:0]                  in_pixel_row,
  input  wire logic [7:0]                  in_pixel_value,
  input  wire logic signed [17:0]          in_coord_u,
  input  wire logic signed [17:0]          in_coord_v,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bms_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                             push_o,
  output logic [EW-1:0]                    entry_o,
  input  wire logic                        full_i
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int XW = bms_pkg::FRAC_W + CW;
  localparam int YW = bms_pkg::FRAC_W + RW;

  function automatic logic [256*CW-1:0] build_col_map();
    logic [256*CW-1:0] m;
    m = '0;
    for (int i = 0; i < 256; i++) begin
      m[i*CW +: CW] = CW'(i % MAX_WIDTH);
    end
    return m;
  endfunction

  function automatic logic [256*RW-1:0] build_row_map();
    logic [256*RW-1:0] m;
    m = '0;
    for (int i = 0; i < 256; i++) begin
      m[i*RW +: RW] = RW'(i % MAX_HEIGHT);
    end
    return m;
  endfunction

  localparam logic [256*CW-1:0] COL_MAP = build_col_map();
  localparam logic [256*RW-1:0] ROW_MAP = build_row_map();

  logic [bms_pkg::CFG_W-1:0] width_r;
  logic [bms_pkg::CFG_W-1:0] height_r;

  logic [WW-1:0]      w_sat;
  logic [HW-1:0]      h_sat;
  logic               accept;
  logic               u_bad;
  logic               v_bad;
  bms_pkg::op_t       op_nxt;

  logic               f1_valid_r;
  bms_pkg::op_t       f1_op_r;
  logic [16:0]        f1_u_r;
  logic [16:0]        f1_v_r;
  logic [CW-1:0]      f1_wm1_r;
  logic [RW-1:0]      f1_hm1_r;
  logic [CW-1:0]      f1_col_r;
  logic [RW-1:0]      f1_row_r;
  logic [7:0]         f1_val_r;

  logic [XW-1:0]      x_prod;
  logic [YW-1:0]      y_prod;

  assign w_sat = (32'(width_r) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_r);
  assign h_sat = (32'(height_r) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_r);

  assign u_bad = in_coord_u[17] || (in_coord_u[16] && (in_coord_u[15:0] != 16'd0));
  assign v_bad = in_coord_v[17] || (in_coord_v[16] && (in_coord_v[15:0] != 16'd0));

  always_comb begin
    if (!in_action) begin
      op_nxt = bms_pkg::OP_WRITE;
    end else if (w_sat == '0 || h_sat == '0 || u_bad || v_bad) begin
      op_nxt = bms_pkg::OP_ZERO;
    end else begin
      op_nxt = bms_pkg::OP_SAMPLE;
    end
  end

  assign busy   = f1_valid_r && full_i;
  assign accept = start && !busy;
  assign push_o = f1_valid_r && !full_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bms_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        bms_pkg::CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (accept) begin
      f1_valid_r <= 1'b1;
    end else if (push_o) begin
      f1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op_r  <= op_nxt;
      f1_u_r   <= in_coord_u[16:0];
      f1_v_r   <= in_coord_v[16:0];
      f1_wm1_r <= CW'(w_sat - WW'(1));
      f1_hm1_r <= RW'(h_sat - HW'(1));
      f1_col_r <= COL_MAP[in_pixel_column*CW +: CW];
      f1_row_r <= ROW_MAP[in_pixel_row*RW +: RW];
      f1_val_r <= in_pixel_value;
    end
  end

  assign x_prod = XW'(XW'(f1_u_r) * XW'(f1_wm1_r));
  assign y_prod = YW'(YW'(f1_v_r) * YW'(f1_hm1_r));

  assign entry_o = {f1_op_r, f1_wm1_r, f1_hm1_r, x_prod, y_prod,
                    f1_col_r, f1_row_r, f1_val_r};

endmodule

`default_nettype wire

FILE: rtl/bms_back.sv
// ----------------------------------------------------------------------------
// bms_back
// Banked 2x2 pixel store and the bilinear blend pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bms_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int EW         = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid_i,
  input  wire logic [EW-1:0]              q_entry_i,
  output logic                            out_valid,
  output logic [bms_pkg::OUT_W-1:0]       out_sample_value
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int FW = bms_pkg::FRAC_W;
  localparam int XW = FW + CW;
  localparam int YW = FW + RW;
  localparam int CWB = (MAX_WIDTH + 1) / 2;
  localparam int RWB = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = CWB * RWB;
  localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [AW-1:0] CWB_A = AW'(CWB);

  localparam int VAL_LO = 0;
  localparam int ROW_LO = VAL_LO + 8;
  localparam int COL_LO = ROW_LO + RW;
  localparam int Y_LO   = COL_LO + CW;
  localparam int X_LO   = Y_LO + YW;
  localparam int HM_LO  = X_LO + XW;
  localparam int WM_LO  = HM_LO + RW;
  localparam int OP_LO  = WM_LO + CW;

  bms_pkg::op_t  op;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [CW-1:0] wcol;
  logic [RW-1:0] wrow;
  logic [7:0]    wval;

  logic [CW-1:0] xi;
  logic [RW-1:0] yi;
  logic [CW-1:0] x1;
  logic [RW-1:0] y1;
  logic          x_step;
  logic          y_step;
  logic [CW-1:0] col_e;
  logic [CW-1:0] col_o;
  logic [RW-1:0] row_e;
  logic [RW-1:0] row_o;
  logic [AW-1:0] w_addr;
  logic          is_write;

  logic [AW-1:0] bank_addr [4];
  logic          bank_we   [4];
  logic [7:0]    bank_q_r  [4];

  logic                s1_valid_r;
  bms_pkg::op_t        s1_op_r;
  logic [FW-1:0]       s1_fx_r;
  logic [FW-1:0]       s1_fy_r;
  logic                s1_xp0_r;
  logic                s1_xp1_r;
  logic                s1_yp0_r;
  logic                s1_yp1_r;

  logic [7:0]    pa;
  logic [7:0]    pb;
  logic [7:0]    pc;
  logic [7:0]    pd;
  logic [FW:0]   wx1;
  logic [23:0]   top_nxt;
  logic [23:0]   bot_nxt;

  logic                s2_valid_r;
  bms_pkg::op_t        s2_op_r;
  logic [23:0]         s2_top_r;
  logic [23:0]         s2_bot_r;
  logic [FW-1:0]       s2_fy_r;

  logic [FW:0]   wy1;
  logic [39:0]   blend;
  logic [bms_pkg::OUT_W-1:0] out_nxt;
  logic                      out_valid_r;
  logic [bms_pkg::OUT_W-1:0] out_value_r;

  assign op   = bms_pkg::op_t'(q_entry_i[OP_LO +: 2]);
  assign wm1  = q_entry_i[WM_LO +: CW];
  assign hm1  = q_entry_i[HM_LO +: RW];
  assign x    = q_entry_i[X_LO +: XW];
  assign y    = q_entry_i[Y_LO +: YW];
  assign wcol = q_entry_i[COL_LO +: CW];
  assign wrow = q_entry_i[ROW_LO +: RW];
  assign wval = q_entry_i[VAL_LO +: 8];

  assign xi = x[FW +: CW];
  assign yi = y[FW +: RW];
  assign x_step = (xi != wm1);
  assign y_step = (yi != hm1);
  assign x1 = x_step ? xi + CW'(1) : xi;
  assign y1 = y_step ? yi + RW'(1) : yi;

  assign col_e = (!xi[0] || !x_step) ? xi : xi + CW'(1);
  assign col_o = ( xi[0] || !x_step) ? xi : xi + CW'(1);
  assign row_e = (!yi[0] || !y_step) ? yi : yi + RW'(1);
  assign row_o = ( yi[0] || !y_step) ? yi : yi + RW'(1);

  assign is_write = q_valid_i && (op == bms_pkg::OP_WRITE);
  assign w_addr   = AW'(wrow >> 1) * CWB_A + AW'(wcol >> 1);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bank_addr[k] = AW'((k[1] ? row_o : row_e) >> 1) * CWB_A
                   + AW'((k[0] ? col_o : col_e) >> 1);
      bank_we[k]   = 1'b0;
      if (is_write) begin
        bank_addr[k] = w_addr;
        bank_we[k]   = ({wrow[0], wcol[0]} == 2'(k));
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (bank_we[g]) begin
        mem[bank_addr[g]] <= wval;
      end
      bank_q_r[g] <= mem[bank_addr[g]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= q_valid_i && (op != bms_pkg::OP_WRITE);
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r  <= op;
    s1_fx_r  <= x[FW-1:0];
    s1_fy_r  <= y[FW-1:0];
    s1_xp0_r <= xi[0];
    s1_xp1_r <= x1[0];
    s1_yp0_r <= yi[0];
    s1_yp1_r <= y1[0];
  end

  assign pa  = bank_q_r[{s1_yp0_r, s1_xp0_r}];
  assign pb  = bank_q_r[{s1_yp0_r, s1_xp1_r}];
  assign pc  = bank_q_r[{s1_yp1_r, s1_xp0_r}];
  assign pd  = bank_q_r[{s1_yp1_r, s1_xp1_r}];
  assign wx1 = bms_pkg::FIX_ONE - (FW+1)'(s1_fx_r);

  assign top_nxt = 24'(pa) * 24'(wx1) + 24'(pb) * 24'(s1_fx_r);
  assign bot_nxt = 24'(pc) * 24'(wx1) + 24'(pd) * 24'(s1_fx_r);

  always_ff @(posedge clk) begin
    s2_op_r  <= s1_op_r;
    s2_top_r <= top_nxt;
    s2_bot_r <= bot_nxt;
    s2_fy_r  <= s1_fy_r;
  end

  assign wy1   = bms_pkg::FIX_ONE - (FW+1)'(s2_fy_r);
  assign blend = 40'(s2_top_r) * 40'(wy1) + 40'(s2_bot_r) * 40'(s2_fy_r);
  assign out_nxt = (s2_op_r == bms_pkg::OP_SAMPLE) ? blend[39:24] : '0;

  always_ff @(posedge clk) begin
    out_value_r <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s2_valid_r))
    else $error("result strobe without a request in flight");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_op_r == bms_pkg::OP_ZERO) |=>
      (out_valid_r && out_value_r == '0))
    else $error("rejected sample gave non-zero result");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (is_write && !s1_valid_r && !s2_valid_r) |=> ##2 !out_valid_r)
    else $error("pixel write produced a result");

endmodule

`default_nettype wire

FILE: rtl/bilinear_mask_sampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_mask_sampler_top
// Bilinear sampler over an 8-bit image held in a 2x2 banked pixel store.
// Request path: front register, queue, s1, s2 and output register.
// One request per clock unless busy; each bank is read or written once a cycle.
// busy rises only when the request queue backs up; the receiver never stalls.
// Reset clears image size and pipeline state; the pixel store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bilinear_mask_sampler_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_action,
  input  wire logic [7:0]                  in_pixel_column,
  input  wire logic [7:0]                  in_pixel_row,
  input  wire logic [7:0]                  in_pixel_value,
  input  wire logic signed [17:0]          in_coord_u,
  input  wire logic signed [17:0]          in_coord_v,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bms_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                             out_valid,
  output logic [bms_pkg::OUT_W-1:0]        out_sample_value
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EW = 2 + 2 * (CW + RW) + 2 * bms_pkg::FRAC_W + CW + RW + 8;

  logic          push;
  logic          q_full;
  logic [EW-1:0] entry;
  logic          q_valid;
  logic [EW-1:0] q_entry;

  bms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .EW         (EW)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_pixel_column (in_pixel_column),
    .in_pixel_row    (in_pixel_row),
    .in_pixel_value  (in_pixel_value),
    .in_coord_u      (in_coord_u),
    .in_coord_v      (in_coord_v),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .push_o          (push),
    .entry_o         (entry),
    .full_i          (q_full)
  );

  bms_queue #(
    .W (EW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  (entry),
    .full_o  (q_full),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  bms_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .EW         (EW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid_i        (q_valid),
    .q_entry_i        (q_entry),
    .out_valid        (out_valid),
    .out_sample_value (out_sample_value)
  );

endmodule

`default_nettype wire
